@@ design/wpc_pkg.sv @@
// wpc_pkg: shared types, header offsets and the crc-16/ccitt-false byte step
// for the waveform packet header parser. No dependencies.

package wpc_pkg;

  // byte position counter width, holds the largest packet length
  localparam int unsigned PosW = 18;

  // header length and crc seed
  localparam logic [PosW-1:0] HdrBytes = 18'd30;
  localparam logic [15:0]     CrcInit  = 16'hFFFF;
  localparam logic [PosW-1:0] LastHdrPos = HdrBytes - 18'd1;

  // header byte offsets, big-endian fields
  localparam logic [4:0] OffType     = 5'd0;
  localparam logic [4:0] OffVersion  = 5'd1;
  localparam logic [4:0] OffTrigHi   = 5'd2;
  localparam logic [4:0] OffTrigLo   = 5'd3;
  localparam logic [4:0] OffHw0      = 5'd4;
  localparam logic [4:0] OffHw1      = 5'd5;
  localparam logic [4:0] OffHw2      = 5'd6;
  localparam logic [4:0] OffHw3      = 5'd7;
  localparam logic [4:0] OffBuild0   = 5'd10;
  localparam logic [4:0] OffBuild1   = 5'd11;
  localparam logic [4:0] OffBuild2   = 5'd12;
  localparam logic [4:0] OffBuild3   = 5'd13;
  localparam logic [4:0] OffEvent0   = 5'd18;
  localparam logic [4:0] OffEvent1   = 5'd19;
  localparam logic [4:0] OffEvent2   = 5'd20;
  localparam logic [4:0] OffEvent3   = 5'd21;
  localparam logic [4:0] OffTpt0     = 5'd22;
  localparam logic [4:0] OffTpt1     = 5'd23;
  localparam logic [4:0] OffTpt2     = 5'd24;
  localparam logic [4:0] OffTpt3     = 5'd25;
  localparam logic [4:0] OffBoard    = 5'd26;
  localparam logic [4:0] OffChan     = 5'd27;
  localparam logic [4:0] OffSampHi   = 5'd28;
  localparam logic [4:0] OffSampLo   = 5'd29;

  // one request held in the input register
  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
    logic       packet_start;
  } in_item_t;

  // one parsed packet header
  typedef struct packed {
    logic [7:0]         packet_type;
    logic [7:0]         packet_version;
    logic [15:0]        trigger_number;
    logic [31:0]        hardware_ident;
    logic [31:0]        build_time;
    logic [31:0]        event_time;
    logic signed [31:0] trigger_point;
    logic [7:0]         board_number;
    logic               channel_kind;
    logic [6:0]         channel_number;
    logic [15:0]        sample_total;
    logic               crc_match;
  } result_t;

  // crc-16/ccitt-false, poly 0x1021, one byte per call
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0] x;
    x = crc[15:8] ^ b;
    x = x ^ {4'h0, x[7:4]};
    return {crc[7:0], 8'h00} ^ {x[3:0], 12'h000} ^ {3'b000, x, 5'b00000} ^ {8'h00, x};
  endfunction

endpackage

@@ design/wpc_in_stage.sv @@
// wpc_in_stage: input register for the byte stream, one request deep.
// Depends on wpc_pkg.

module wpc_in_stage import wpc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic [7:0] data_byte_i,
  input  logic     packet_start_i,
  input  logic     advance_i,
  output logic     in_ready_o,
  output in_item_t item_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       start_q;
  logic       load;

  // free when empty or when the held byte moves on this cycle
  assign in_ready_o = !valid_q || advance_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  // control bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q  <= data_byte_i;
      start_q <= packet_start_i;
    end
  end

  assign item_o.valid        = valid_q;
  assign item_o.data_byte    = byte_q;
  assign item_o.packet_start = start_q;

endmodule

@@ design/wpc_parse.sv @@
// wpc_parse: packet position tracking, header capture, running crc and the
// result register. Depends on wpc_pkg.

module wpc_parse import wpc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  in_item_t item_i,
  input  logic     out_ready_i,
  output logic     advance_o,
  output logic     out_valid_o,
  output result_t  result_o
);

  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW-1:0] end_q, end_d;
  logic [15:0]     crc_q, crc_d;
  logic [7:0]      csh_q, csh_d;
  result_t         hdr_q, hdr_d;
  result_t         res_q, res_d;
  logic            out_valid_q, out_valid_d;

  logic [PosW-1:0] p;
  logic [15:0]     crc_cur;
  logic [7:0]      b;
  logic            emit;

  // the held byte moves when the result slot is free or draining
  assign advance_o = item_i.valid && (!out_valid_q || out_ready_i);
  assign b         = item_i.data_byte;

  // position, crc and header update for the byte in the input register
  always_comb begin
    p       = item_i.packet_start ? '0 : pos_q;
    crc_cur = item_i.packet_start ? CrcInit : crc_q;
    pos_d   = pos_q;
    end_d   = end_q;
    crc_d   = crc_q;
    csh_d   = csh_q;
    hdr_d   = hdr_q;
    emit    = 1'b0;
    if (advance_o) begin
      crc_d = crc_cur;
      pos_d = p;
      if (p < HdrBytes) begin
        crc_d = crc_step(crc_cur, b);
        pos_d = p + 1'b1;
        case (p[4:0])
          OffType:    hdr_d.packet_type           = b;
          OffVersion: hdr_d.packet_version        = b;
          OffTrigHi:  hdr_d.trigger_number[15:8]  = b;
          OffTrigLo:  hdr_d.trigger_number[7:0]   = b;
          OffHw0:     hdr_d.hardware_ident[31:24] = b;
          OffHw1:     hdr_d.hardware_ident[23:16] = b;
          OffHw2:     hdr_d.hardware_ident[15:8]  = b;
          OffHw3:     hdr_d.hardware_ident[7:0]   = b;
          OffBuild0:  hdr_d.build_time[31:24]     = b;
          OffBuild1:  hdr_d.build_time[23:16]     = b;
          OffBuild2:  hdr_d.build_time[15:8]      = b;
          OffBuild3:  hdr_d.build_time[7:0]       = b;
          OffEvent0:  hdr_d.event_time[31:24]     = b;
          OffEvent1:  hdr_d.event_time[23:16]     = b;
          OffEvent2:  hdr_d.event_time[15:8]      = b;
          OffEvent3:  hdr_d.event_time[7:0]       = b;
          OffTpt0:    hdr_d.trigger_point[31:24]  = b;
          OffTpt1:    hdr_d.trigger_point[23:16]  = b;
          OffTpt2:    hdr_d.trigger_point[15:8]   = b;
          OffTpt3:    hdr_d.trigger_point[7:0]    = b;
          OffBoard:   hdr_d.board_number          = b;
          OffChan: begin
            hdr_d.channel_kind   = b[7];
            hdr_d.channel_number = b[6:0];
          end
          OffSampHi:  hdr_d.sample_total[15:8]    = b;
          OffSampLo:  hdr_d.sample_total[7:0]     = b;
          default:    hdr_d = hdr_q;
        endcase
        // last header byte: the checksum starts after 2*N sample bytes
        if (p == LastHdrPos) begin
          end_d = HdrBytes + {1'b0, hdr_q.sample_total[15:8], b, 1'b0};
        end
      end else if (p < end_q) begin
        crc_d = crc_step(crc_cur, b);
        pos_d = p + 1'b1;
      end else if (p == end_q) begin
        csh_d = b;
        pos_d = p + 1'b1;
      end else if (p == end_q + 1'b1) begin
        emit  = 1'b1;
        pos_d = p + 1'b1;
      end
    end
  end

  // result register load and hand-off
  always_comb begin
    res_d       = res_q;
    out_valid_d = out_valid_q;
    if (emit) begin
      res_d           = hdr_q;
      res_d.crc_match = (crc_cur == {csh_q, b});
      out_valid_d     = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      end_q       <= '0;
      crc_q       <= CrcInit;
      csh_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      end_q       <= end_d;
      crc_q       <= crc_d;
      csh_q       <= csh_d;
      out_valid_q <= out_valid_d;
    end
  end

  // captured header and result payload
  always_ff @(posedge clk_i) begin
    hdr_q <= hdr_d;
    res_q <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

endmodule

@@ design/waveform_packet_header_crc_parser.sv @@
// waveform_packet_header_crc_parser: top level, byte-stream digitizer packet
// parser with crc-16/ccitt-false check. Depends on wpc_pkg, wpc_in_stage, wpc_parse.
// Throughput: one byte per cycle; a blocked result register stalls the input.
// Result path: the last checksum byte passes the input register, then the result
// register, which raises the result valid.
// Reset: rst_ni async active low; clears position, end and checksum state and valid flags, seeds the crc.

module waveform_packet_header_crc_parser import wpc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         data_byte_i,
  input  logic               packet_start_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         packet_type_o,
  output logic [7:0]         packet_version_o,
  output logic [15:0]        trigger_number_o,
  output logic [31:0]        hardware_ident_o,
  output logic [31:0]        build_time_o,
  output logic [31:0]        event_time_o,
  output logic signed [31:0] trigger_point_o,
  output logic [7:0]         board_number_o,
  output logic               channel_kind_o,
  output logic [6:0]         channel_number_o,
  output logic [15:0]        sample_total_o,
  output logic               crc_match_o
);

  in_item_t item;
  result_t  res;
  logic     advance;

  // input register
  wpc_in_stage u_in (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .data_byte_i   (data_byte_i),
    .packet_start_i(packet_start_i),
    .advance_i     (advance),
    .in_ready_o    (in_ready_o),
    .item_o        (item)
  );

  // parser and result register
  wpc_parse u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item),
    .out_ready_i(out_ready_i),
    .advance_o  (advance),
    .out_valid_o(out_valid_o),
    .result_o   (res)
  );

  // result fields
  assign packet_type_o    = res.packet_type;
  assign packet_version_o = res.packet_version;
  assign trigger_number_o = res.trigger_number;
  assign hardware_ident_o = res.hardware_ident;
  assign build_time_o     = res.build_time;
  assign event_time_o     = res.event_time;
  assign trigger_point_o  = res.trigger_point;
  assign board_number_o   = res.board_number;
  assign channel_kind_o   = res.channel_kind;
  assign channel_number_o = res.channel_number;
  assign sample_total_o   = res.sample_total;
  assign crc_match_o      = res.crc_match;

endmodule

@@ design/wpc_checker.sv @@
// wpc_checker: port-level assertions for the packet parser, bound to the top.
// Depends on waveform_packet_header_crc_parser.

module wpc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic [7:0]         data_byte_i,
  input logic               packet_start_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [7:0]         packet_type_o,
  input logic [7:0]         packet_version_o,
  input logic [15:0]        trigger_number_o,
  input logic [31:0]        hardware_ident_o,
  input logic [31:0]        build_time_o,
  input logic [31:0]        event_time_o,
  input logic signed [31:0] trigger_point_o,
  input logic [7:0]         board_number_o,
  input logic               channel_kind_o,
  input logic [6:0]         channel_number_o,
  input logic [15:0]        sample_total_o,
  input logic               crc_match_o
);

  // no result is pending right out of reset
  a_reset_idle: assert property (@(posedge clk_i) $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid at reset release");

  // input only stalls behind a blocked result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without a blocked result");

  // packets are at least 32 bytes, so results never come back to back
  a_result_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i) |=> !out_valid_o)
    else $error("two results in consecutive cycles");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(sample_total_o)
      && $stable(crc_match_o) && $stable(packet_type_o) && $stable(trigger_point_o)))
    else $error("stalled result changed");

endmodule

bind waveform_packet_header_crc_parser wpc_checker u_wpc_checker (.*);
